### src/ecnrtt_pkg.sv
// shared types and constants for the ecn/rtt window update unit
package ecnrtt_pkg;

  localparam int TALLY_W          = 20;
  localparam int SAMPLE_THRESHOLD = 64;
  localparam int RTT_W            = 40;
  localparam int GAIN_W           = 16;
  localparam int WIN_W            = 32;
  localparam int SEG_W            = 16;
  localparam int CNT_W            = 10;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 40;
  localparam int LEVEL_W          = 2;

  // gain times tally, full width
  localparam int TERM_W   = GAIN_W + TALLY_W;
  // low slice of the gain difference per partial product
  localparam int SLICE_W  = TERM_W / 2;
  localparam int PART_W   = WIN_W + SLICE_W;
  localparam int PROD_W   = WIN_W + TERM_W;
  localparam int SEGT_W   = TERM_W + SEG_W;
  localparam int BASE_W   = SEGT_W + 1;
  localparam int SUM_W    = PROD_W + 2;
  localparam int VAL_W    = WIN_W + 1;
  localparam int FRAC_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RTT_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FREE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CONGESTED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_MILD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WINDOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE   = 3'd6;

  localparam logic [RTT_W-1:0]  RST_RTT_THRESHOLD  = 40'd10000000;
  localparam logic [GAIN_W-1:0] RST_GAIN_FREE      = 16'd655;
  localparam logic [GAIN_W-1:0] RST_GAIN_CONGESTED = 16'd6554;
  localparam logic [GAIN_W-1:0] RST_GAIN_MILD      = 16'd66;
  localparam logic [SEG_W-1:0]  RST_SEGMENT_SIZE   = 16'd1500;

  localparam logic [LEVEL_W-1:0] LEVEL_FREE      = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_MILD      = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_CONGESTED = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TALLY,
    ST_MUL_GAIN,
    ST_MUL_SEG,
    ST_MUL_WIN,
    ST_SUM_PROD,
    ST_ROUND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic tally;
    logic mul_gain;
    logic mul_seg;
    logic mul_win;
    logic sum_prod;
    logic round;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic period_done;
    logic out_busy;
  } status_t;

endpackage

### src/ecnrtt_ctrl.sv
// sequencer for one acknowledgement request at a time
module ecnrtt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ecnrtt_pkg::status_t status,
  output ecnrtt_pkg::cmd_t    cmd
);

  ecnrtt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ecnrtt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ecnrtt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ecnrtt_pkg::ST_TALLY;
        end
      end
      ecnrtt_pkg::ST_TALLY: begin
        cmd.tally = 1'b1;
        state_nxt = status.period_done ? ecnrtt_pkg::ST_MUL_GAIN : ecnrtt_pkg::ST_EMIT;
      end
      ecnrtt_pkg::ST_MUL_GAIN: begin
        cmd.mul_gain = 1'b1;
        state_nxt    = ecnrtt_pkg::ST_MUL_SEG;
      end
      ecnrtt_pkg::ST_MUL_SEG: begin
        cmd.mul_seg = 1'b1;
        state_nxt   = ecnrtt_pkg::ST_MUL_WIN;
      end
      ecnrtt_pkg::ST_MUL_WIN: begin
        cmd.mul_win = 1'b1;
        state_nxt   = ecnrtt_pkg::ST_SUM_PROD;
      end
      ecnrtt_pkg::ST_SUM_PROD: begin
        cmd.sum_prod = 1'b1;
        state_nxt    = ecnrtt_pkg::ST_ROUND;
      end
      ecnrtt_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = ecnrtt_pkg::ST_EMIT;
      end
      ecnrtt_pkg::ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ecnrtt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ecnrtt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### src/ecnrtt_dp.sv
// registers, tallies, multipliers and clamp of the window update
module ecnrtt_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ecnrtt_pkg::cmd_t                     cmd,
  output ecnrtt_pkg::status_t                  status,
  input  logic                                 in_ecn_mark,
  input  logic [ecnrtt_pkg::RTT_W-1:0]         in_rtt_sample,
  input  logic [ecnrtt_pkg::CNT_W-1:0]         in_acked_count,
  input  logic [ecnrtt_pkg::WIN_W-1:0]         in_current_window,
  input  logic                                 cfg_we,
  input  logic [ecnrtt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ecnrtt_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_window_valid,
  output logic [ecnrtt_pkg::WIN_W-1:0]         out_new_window,
  output logic [ecnrtt_pkg::LEVEL_W-1:0]       out_congestion_level
);

  // configuration
  logic [ecnrtt_pkg::RTT_W-1:0]  rtt_thr_r;
  logic [ecnrtt_pkg::GAIN_W-1:0] gain_free_r, gain_cong_r, gain_mild_r;
  logic [ecnrtt_pkg::WIN_W-1:0]  min_win_r, max_win_r;
  logic [ecnrtt_pkg::SEG_W-1:0]  mss_r;

  // request
  logic                          ecn_r;
  logic [ecnrtt_pkg::RTT_W-1:0]  rtt_r;
  logic [ecnrtt_pkg::CNT_W-1:0]  cnt_r;
  logic [ecnrtt_pkg::WIN_W-1:0]  cwnd_r;

  // tallies
  logic [ecnrtt_pkg::TALLY_W-1:0] cong_r, mild_r, free_r, samp_r;
  logic [ecnrtt_pkg::TALLY_W-1:0] cong_nxt, mild_nxt, free_nxt, samp_nxt;
  logic [ecnrtt_pkg::TALLY_W-1:0] cnt_ext;
  logic                           active;

  // arithmetic
  logic [ecnrtt_pkg::TERM_W-1:0]  up_r, down_r, mterm_r, diff_r;
  logic                           neg_r;
  logic [ecnrtt_pkg::SEGT_W-1:0]  segterm_r;
  logic [ecnrtt_pkg::PART_W-1:0]  plo_r, phi_r;
  logic [ecnrtt_pkg::BASE_W-1:0]  base_r;
  logic [ecnrtt_pkg::PROD_W-1:0]  prod_r;
  logic [ecnrtt_pkg::SUM_W-1:0]   sum;
  logic [ecnrtt_pkg::VAL_W-1:0]   val_r, val_nxt;
  logic [ecnrtt_pkg::VAL_W-1:0]   lower, clamped;
  logic                           win_valid_r;
  logic [ecnrtt_pkg::LEVEL_W-1:0] level_r;

  // output register
  logic                           out_valid_r;
  logic                           out_wv_r;
  logic [ecnrtt_pkg::WIN_W-1:0]   out_win_r;
  logic [ecnrtt_pkg::LEVEL_W-1:0] out_lvl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rtt_thr_r   <= ecnrtt_pkg::RST_RTT_THRESHOLD;
      gain_free_r <= ecnrtt_pkg::RST_GAIN_FREE;
      gain_cong_r <= ecnrtt_pkg::RST_GAIN_CONGESTED;
      gain_mild_r <= ecnrtt_pkg::RST_GAIN_MILD;
      min_win_r   <= '0;
      max_win_r   <= '0;
      mss_r       <= ecnrtt_pkg::RST_SEGMENT_SIZE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ecnrtt_pkg::CFG_RTT_THRESHOLD:  rtt_thr_r   <= cfg_data;
        ecnrtt_pkg::CFG_GAIN_FREE:      gain_free_r <= cfg_data[ecnrtt_pkg::GAIN_W-1:0];
        ecnrtt_pkg::CFG_GAIN_CONGESTED: gain_cong_r <= cfg_data[ecnrtt_pkg::GAIN_W-1:0];
        ecnrtt_pkg::CFG_GAIN_MILD:      gain_mild_r <= cfg_data[ecnrtt_pkg::GAIN_W-1:0];
        ecnrtt_pkg::CFG_MIN_WINDOW:     min_win_r   <= cfg_data[ecnrtt_pkg::WIN_W-1:0];
        ecnrtt_pkg::CFG_MAX_WINDOW:     max_win_r   <= cfg_data[ecnrtt_pkg::WIN_W-1:0];
        ecnrtt_pkg::CFG_SEGMENT_SIZE:   mss_r       <= cfg_data[ecnrtt_pkg::SEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ecn_r  <= in_ecn_mark;
      rtt_r  <= in_rtt_sample;
      cnt_r  <= in_acked_count;
      cwnd_r <= in_current_window;
    end
  end

  // tally update
  always_comb begin
    cnt_ext  = ecnrtt_pkg::TALLY_W'(cnt_r);
    active   = (cnt_r != '0) && (mss_r != '0);
    cong_nxt = cong_r;
    mild_nxt = mild_r;
    free_nxt = free_r;
    samp_nxt = samp_r;
    if (active) begin
      priority if (ecn_r) begin
        cong_nxt = cong_r + cnt_ext;
      end else if (rtt_r > rtt_thr_r) begin
        mild_nxt = mild_r + cnt_ext;
      end else begin
        free_nxt = free_r + cnt_ext;
      end
      samp_nxt = samp_r + cnt_ext;
    end
  end

  assign status.period_done =
    active && (samp_nxt >= ecnrtt_pkg::TALLY_W'(ecnrtt_pkg::SAMPLE_THRESHOLD));
  assign status.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cong_r <= '0;
      mild_r <= '0;
      free_r <= '0;
      samp_r <= '0;
    end else if (cmd.tally) begin
      cong_r <= cong_nxt;
      mild_r <= mild_nxt;
      free_r <= free_nxt;
      samp_r <= samp_nxt;
    end else if (cmd.mul_gain) begin
      cong_r <= '0;
      mild_r <= '0;
      free_r <= '0;
      samp_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tally) begin
      win_valid_r <= status.period_done;
      if (cong_nxt != '0) begin
        level_r <= ecnrtt_pkg::LEVEL_CONGESTED;
      end else if (mild_nxt != '0) begin
        level_r <= ecnrtt_pkg::LEVEL_MILD;
      end else begin
        level_r <= ecnrtt_pkg::LEVEL_FREE;
      end
    end
  end

  // gain products, then segment term and difference, then window products, product sum and rounding
  always_ff @(posedge clk) begin
    if (cmd.mul_gain) begin
      up_r    <= ecnrtt_pkg::TERM_W'(gain_free_r) * ecnrtt_pkg::TERM_W'(free_r);
      down_r  <= ecnrtt_pkg::TERM_W'(gain_cong_r) * ecnrtt_pkg::TERM_W'(cong_r);
      mterm_r <= ecnrtt_pkg::TERM_W'(gain_mild_r) * ecnrtt_pkg::TERM_W'(mild_r);
    end
    if (cmd.mul_seg) begin
      segterm_r <= ecnrtt_pkg::SEGT_W'(mterm_r) * ecnrtt_pkg::SEGT_W'(mss_r);
      neg_r     <= up_r < down_r;
      diff_r    <= (up_r < down_r) ? (down_r - up_r) : (up_r - down_r);
    end
    if (cmd.mul_win) begin
      plo_r  <= ecnrtt_pkg::PART_W'(cwnd_r)
              * ecnrtt_pkg::PART_W'(diff_r[ecnrtt_pkg::SLICE_W-1:0]);
      phi_r  <= ecnrtt_pkg::PART_W'(cwnd_r)
              * ecnrtt_pkg::PART_W'(diff_r[ecnrtt_pkg::TERM_W-1:ecnrtt_pkg::SLICE_W]);
      base_r <= ecnrtt_pkg::BASE_W'({cwnd_r, {ecnrtt_pkg::FRAC_W{1'b0}}})
              + ecnrtt_pkg::BASE_W'(segterm_r);
    end
    if (cmd.sum_prod) begin
      prod_r <= ecnrtt_pkg::PROD_W'(plo_r)
              + (ecnrtt_pkg::PROD_W'(phi_r) << ecnrtt_pkg::SLICE_W);
    end
    if (cmd.round) begin
      val_r <= val_nxt;
    end
  end

  // signed combine, round to nearest and saturate to 33 bits
  always_comb begin
    if (neg_r) begin
      sum = ecnrtt_pkg::SUM_W'(base_r) - ecnrtt_pkg::SUM_W'(prod_r);
    end else begin
      sum = ecnrtt_pkg::SUM_W'(base_r) + ecnrtt_pkg::SUM_W'(prod_r);
    end
    sum = sum + ecnrtt_pkg::SUM_W'(1 << (ecnrtt_pkg::FRAC_W - 1));
    if (neg_r && (ecnrtt_pkg::PROD_W'(base_r) < prod_r)) begin
      val_nxt = '0;
    end else if (sum[ecnrtt_pkg::SUM_W-1:ecnrtt_pkg::WIN_W+ecnrtt_pkg::FRAC_W] != '0) begin
      val_nxt = {1'b1, {ecnrtt_pkg::WIN_W{1'b0}}};
    end else begin
      val_nxt = {1'b0, sum[ecnrtt_pkg::WIN_W+ecnrtt_pkg::FRAC_W-1:ecnrtt_pkg::FRAC_W]};
    end
  end

  // clamp
  always_comb begin
    lower = (min_win_r > ecnrtt_pkg::WIN_W'(mss_r))
          ? ecnrtt_pkg::VAL_W'(min_win_r) : ecnrtt_pkg::VAL_W'(mss_r);
    clamped = val_r;
    if (clamped < lower) begin
      clamped = lower;
    end
    if ((max_win_r != '0) && (clamped > ecnrtt_pkg::VAL_W'(max_win_r))) begin
      clamped = ecnrtt_pkg::VAL_W'(max_win_r);
    end
    if (clamped[ecnrtt_pkg::WIN_W]) begin
      clamped = {1'b0, {ecnrtt_pkg::WIN_W{1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_wv_r  <= win_valid_r;
      out_win_r <= win_valid_r ? clamped[ecnrtt_pkg::WIN_W-1:0] : '0;
      out_lvl_r <= win_valid_r ? level_r : ecnrtt_pkg::LEVEL_FREE;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_window_valid     = out_wv_r;
  assign out_new_window       = out_win_r;
  assign out_congestion_level = out_lvl_r;

endmodule

### src/ecn_rtt_window_update_unit.sv
// top level of the ecn/rtt congestion window update unit
// a request that does not end a period passes through the tally and emit states;
// the ack that ends a period also passes the gain, segment and window multiplies,
// product sum and round states; emit waits while a held output is not taken
// the sequencer handles one request at a time through the shared datapath
// reset: synchronous, restores register defaults and clears all tallies
module ecn_rtt_window_update_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_ecn_mark,
  input  logic [ecnrtt_pkg::RTT_W-1:0]      in_rtt_sample,
  input  logic [ecnrtt_pkg::CNT_W-1:0]      in_acked_count,
  input  logic [ecnrtt_pkg::WIN_W-1:0]      in_current_window,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_window_valid,
  output logic [ecnrtt_pkg::WIN_W-1:0]      out_new_window,
  output logic [ecnrtt_pkg::LEVEL_W-1:0]    out_congestion_level,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ecnrtt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ecnrtt_pkg::CFG_DATA_W-1:0] cfg_data
);

  ecnrtt_pkg::cmd_t    cmd;
  ecnrtt_pkg::status_t status;

  assign cfg_ready = 1'b1;

  ecnrtt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ecnrtt_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_ecn_mark          (in_ecn_mark),
    .in_rtt_sample        (in_rtt_sample),
    .in_acked_count       (in_acked_count),
    .in_current_window    (in_current_window),
    .cfg_we               (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_window_valid     (out_window_valid),
    .out_new_window       (out_new_window),
    .out_congestion_level (out_congestion_level)
  );

endmodule
